FILE: sv/lkx_pkg.sv
// Package for the LCG keystream XOR cipher: codes, constants and the queue entry type.
// Used by lkx_front, lkx_queue, lkx_back and lcg_keystream_xor_cipher.
package lkx_pkg;

	// Generator constants.
	localparam logic [31:0] LCG_MULT  = 32'h0808_8405;
	localparam logic [31:0] LCG_START = 32'h04A8_0B38;
	// Generator value one advance after reset, with the key at its reset value of zero.
	localparam logic [63:0] LCG_PROD0 = 64'(LCG_START) * 64'(LCG_MULT);
	localparam logic [31:0] LCG_NEXT0 = LCG_PROD0[31:0];

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LIMIT_W = 17;
	localparam int unsigned STATE_W = 32;

	// Word limit values.
	localparam logic [LIMIT_W-1:0] LIMIT_UNLIMITED = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_TYPE_LONG = 17'd12;
	localparam logic [LIMIT_W-1:0] LIMIT_TYPE_SHORT = 17'd4;

	// Packet types that select a word limit.
	localparam logic [7:0] PTYPE_LONG    = 8'h02;
	localparam logic [7:0] PTYPE_SHORT_A = 8'h04;
	localparam logic [7:0] PTYPE_SHORT_B = 8'h06;

	// Configuration register indexes.
	localparam logic CFG_KEY    = 1'b0;
	localparam logic CFG_XOR_EN = 1'b1;

	// Queue between the front and back parts.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Input action codes.
	typedef enum logic [1:0] {
		ACT_DATA  = 2'd0,
		ACT_LIMIT = 2'd1,
		ACT_TYPE  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// What the back part does with an item.
	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_LIMIT,
		KIND_NONE
	} kind_t;

	// One classified item.
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data_byte;
		logic               last;
		logic [LIMIT_W-1:0] new_limit;
		logic               type_error;
	} lkx_entry_t;

endpackage

FILE: sv/lcg_keystream_xor_cipher.sv
// Top level of the LCG keystream XOR cipher: configuration registers and the front,
// queue and back parts. Depends on lkx_pkg, lkx_front, lkx_queue and lkx_back.
//
// Usage:
// Items enter on the in channel (in_valid/in_ready) with action, data_byte, end_of_packet,
// limit_value and packet_type. Every item gives exactly one result on the out channel
// (out_valid/out_ready) with out_byte, out_last and type_error, in input order.
// Data bytes are XORed with the generator byte at their word position; limit actions
// set the word limit and return a zero result, with type_error set for an unknown type.
// A result passes the front stage, the queue and the output register before it is offered.
// Throughput is one item per cycle while results are taken: the next generator value is
// always held ready by a single constant multiplier in the back part, so a word start
// never stalls. A four-entry queue separates the front decode stage from the back part;
// when the receiver stalls, the output register holds its result, the queue fills, and
// in_ready drops only once the queue and the front stage are full. No result is dropped.
// Reset (arst_n low) clears the generator to its start value, the limit to unlimited, the
// byte position and bypass flag, empties the pipeline, sets the key to zero and the XOR
// enable to one. The user must write the registers through cfg_we/cfg_index/cfg_wdata,
// index 0 the key, 1 the XOR enable, only while no item is in flight; no logic checks it.
module lcg_keystream_xor_cipher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [lkx_pkg::BYTE_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [lkx_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        end_of_packet,
	input  logic [lkx_pkg::LIMIT_W-1:0] limit_value,
	input  logic [7:0]                  packet_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lkx_pkg::BYTE_W-1:0]  out_byte,
	output logic                        out_last,
	output logic                        type_error
);
	import lkx_pkg::*;

	logic [BYTE_W-1:0] cipher_key_q;
	logic              xor_enable_q;
	logic              push_valid;
	logic              push_ready;
	lkx_entry_t        push_entry;
	logic              pop_valid;
	logic              pop_ready;
	lkx_entry_t        pop_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= '0;
			xor_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY:    cipher_key_q <= cfg_wdata;
				CFG_XOR_EN: xor_enable_q <= cfg_wdata[0];
				default:    cipher_key_q <= cipher_key_q;
			endcase
		end
	end

	// Decode stage.
	lkx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.limit_value   (limit_value),
		.packet_type   (packet_type),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_entry    (push_entry)
	);

	// Decoupling queue.
	lkx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Keystream and limit processing.
	lkx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cipher_key (cipher_key_q),
		.xor_enable (xor_enable_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.type_error (type_error)
	);

endmodule

FILE: sv/lkx_front.sv
// Front part: accepts input items, decodes the action and works out any new word limit.
// Depends on lkx_pkg.
module lkx_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [lkx_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        end_of_packet,
	input  logic [lkx_pkg::LIMIT_W-1:0] limit_value,
	input  logic [7:0]                  packet_type,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lkx_pkg::lkx_entry_t         push_entry
);
	import lkx_pkg::*;

	logic       valid_s1;
	lkx_entry_t entry_s1;
	lkx_entry_t entry_d;

	// The stage takes a new item when it is empty or its item moves to the queue.
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	// Classify the item and resolve the limit it asks for.
	always_comb begin
		entry_d            = '0;
		entry_d.kind       = KIND_NONE;
		entry_d.data_byte  = data_byte;
		entry_d.last       = end_of_packet;
		entry_d.new_limit  = LIMIT_UNLIMITED;
		entry_d.type_error = 1'b0;
		case (action_t'(action))
			ACT_DATA: begin
				entry_d.kind = KIND_DATA;
			end
			ACT_LIMIT: begin
				entry_d.kind = KIND_LIMIT;
				// Any negative limit means unlimited.
				entry_d.new_limit = limit_value[LIMIT_W-1] ? LIMIT_UNLIMITED : limit_value;
			end
			ACT_TYPE: begin
				if (packet_type == PTYPE_LONG) begin
					entry_d.kind      = KIND_LIMIT;
					entry_d.new_limit = LIMIT_TYPE_LONG;
				end else if (packet_type == PTYPE_SHORT_A || packet_type == PTYPE_SHORT_B) begin
					entry_d.kind      = KIND_LIMIT;
					entry_d.new_limit = LIMIT_TYPE_SHORT;
				end else begin
					entry_d.type_error = 1'b1;
				end
			end
			default: begin
				entry_d.kind = KIND_NONE;
			end
		endcase
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= entry_d;
		end
	end

	// An item that sets a limit never carries a type error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && entry_s1.kind == KIND_LIMIT) |-> !entry_s1.type_error)
		else $error("limit item marked as type error");

	// A held item stays put while the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !push_ready) |=> (valid_s1 && $stable(entry_s1)))
		else $error("front stage lost an item while stalled");

	// An unknown packet type never sets a limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && entry_s1.type_error) |-> entry_s1.kind == KIND_NONE)
		else $error("type error item would change the limit");

endmodule

FILE: sv/lkx_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on lkx_pkg.
module lkx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lkx_pkg::lkx_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output lkx_pkg::lkx_entry_t pop_entry
);
	import lkx_pkg::*;

	lkx_entry_t           slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// The fill count always matches the pointer distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(wr_ptr_q - rd_ptr_q) == count_q[Q_PTR_W-1:0]))
		else $error("queue count out of step with pointers");

	// A transfer into a full queue would overwrite the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(count_q) == Q_CNT_W'(Q_DEPTH) && !$past(pop) |-> count_q == Q_CNT_W'(Q_DEPTH))
		else $error("full queue changed without a pop");

endmodule

FILE: sv/lkx_back.sv
// Back part: runs the generator, the word limit and the packet framing, one item per cycle
// while out_ready allows, and holds the result in an output register. Depends on lkx_pkg.
module lkx_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lkx_pkg::BYTE_W-1:0] cipher_key,
	input  logic                       xor_enable,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  lkx_pkg::lkx_entry_t        pop_entry,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lkx_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last,
	output logic                       type_error
);
	import lkx_pkg::*;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] next_q;
	logic [LIMIT_W-1:0] words_left_q;
	logic [1:0]         byte_pos_q;
	logic               bypass_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;
	logic               type_error_q;

	logic               take;
	logic               is_data;
	logic               ciphering;
	logic               at_word;
	logic               limit_hit;
	logic               advance;
	logic [STATE_W-1:0] key_word;
	logic [BYTE_W-1:0]  key_byte;
	logic [BYTE_W-1:0]  res_byte;
	logic [STATE_W-1:0] mul_src;
	logic [STATE_W-1:0] mul_prod;

	assign pop_ready  = !out_valid_q || out_ready;
	assign take       = pop_valid && pop_ready;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign type_error = type_error_q;

	// Keystream decision for a data byte.
	assign is_data   = take && pop_entry.kind == KIND_DATA;
	assign ciphering = is_data && xor_enable && !bypass_q;
	assign at_word   = ciphering && byte_pos_q == 2'd0;
	assign limit_hit = at_word && words_left_q == '0;
	assign advance   = at_word && words_left_q != '0;

	// At a word start the precomputed next value is the one in use.
	assign key_word = advance ? next_q : state_q;
	always_comb begin
		case (byte_pos_q)
			2'd0:    key_byte = key_word[7:0];
			2'd1:    key_byte = key_word[15:8];
			2'd2:    key_byte = key_word[23:16];
			default: key_byte = key_word[31:24];
		endcase
	end
	assign res_byte = (ciphering && !limit_hit) ? (pop_entry.data_byte ^ key_byte)
		: pop_entry.data_byte;

	// The next generator value is kept one advance ahead, so an advance never waits.
	assign mul_src  = advance ? next_q : state_q;
	assign mul_prod = mul_src * LCG_MULT;

	// Generator registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LCG_START;
			next_q  <= LCG_NEXT0;
		end else begin
			if (advance) begin
				state_q <= next_q;
			end
			next_q <= mul_prod + STATE_W'(cipher_key);
		end
	end

	// Word limit and packet framing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= LIMIT_UNLIMITED;
			byte_pos_q   <= 2'd0;
			bypass_q     <= 1'b0;
		end else if (take) begin
			case (pop_entry.kind)
				KIND_DATA: begin
					if (advance && !words_left_q[LIMIT_W-1]) begin
						words_left_q <= words_left_q - 1'b1;
					end
					if (pop_entry.last) begin
						byte_pos_q <= 2'd0;
						bypass_q   <= 1'b0;
					end else begin
						byte_pos_q <= byte_pos_q + 2'd1;
						bypass_q   <= bypass_q || limit_hit;
					end
				end
				KIND_LIMIT: begin
					words_left_q <= pop_entry.new_limit;
				end
				default: begin
					words_left_q <= words_left_q;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// Output register payload; limit and unused actions give zero byte and last.
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= is_data ? res_byte : '0;
			out_last_q   <= is_data && pop_entry.last;
			type_error_q <= pop_entry.type_error;
		end
	end

	// A negative limit is only ever the unlimited mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		words_left_q[LIMIT_W-1] |-> words_left_q == LIMIT_UNLIMITED)
		else $error("word limit below minus one");

	// With the key steady, the precomputed value is one advance ahead of the state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$stable(cipher_key) |-> next_q == STATE_W'(state_q * LCG_MULT) + STATE_W'(cipher_key))
		else $error("precomputed generator value out of step");

	// An error result carries no byte and no packet end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && type_error_q) |-> (out_byte_q == '0 && !out_last_q))
		else $error("type error result with payload");

	// Bypass never outlives the end of a packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(is_data && pop_entry.last) |=> !bypass_q && byte_pos_q == 2'd0)
		else $error("framing not cleared at end of packet");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for lcg_keystream_xor_cipher: directed table, then random packets.
// Depends on lkx_pkg and the lcg_keystream_xor_cipher RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
	import lkx_pkg::*;

	localparam int unsigned PHASE_ITEMS    = 260;
	localparam int unsigned NUM_PHASES     = 5;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned MAX_PRINTS     = 40;

	// One result of the cipher.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              err;
	} cipher_out_t;

	// One row of the directed table; the typed expectation is used only where typed is set.
	typedef struct packed {
		action_t            act;
		logic [BYTE_W-1:0]  data;
		logic               eop;
		logic [LIMIT_W-1:0] limit;
		logic [7:0]         ptype;
		logic               typed;
		cipher_out_t        want;
	} stim_row_t;

	localparam int unsigned NUM_ROWS = 27;

	// Directed rows, starting right after reset with key zero and the cipher enabled.
	stim_row_t directed_rows [NUM_ROWS] = '{
		// First word from the start value: extremes of the byte.
		'{ACT_DATA,  8'h00, 1'b0, 17'h00000, 8'h00, 1'b0, '0},
		'{ACT_DATA,  8'hFF, 1'b0, 17'h1FFFF, 8'hFF, 1'b0, '0},
		'{ACT_DATA,  8'h5A, 1'b1, 17'h0AAAA, 8'h55, 1'b0, '0},
		// Limit of one word: one word is ciphered, then the rest passes through.
		'{ACT_LIMIT, 8'hFF, 1'b1, 17'd1,     8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_DATA,  8'h01, 1'b0, 17'h15555, 8'h02, 1'b0, '0},
		'{ACT_DATA,  8'h80, 1'b0, 17'h00000, 8'h04, 1'b0, '0},
		'{ACT_DATA,  8'h7E, 1'b0, 17'h1FFFF, 8'h06, 1'b0, '0},
		'{ACT_DATA,  8'hC3, 1'b0, 17'h00001, 8'h00, 1'b0, '0},
		'{ACT_DATA,  8'h96, 1'b0, 17'h00000, 8'h00, 1'b1, '{8'h96, 1'b0, 1'b0}},
		'{ACT_DATA,  8'h69, 1'b1, 17'h00000, 8'h00, 1'b1, '{8'h69, 1'b1, 1'b0}},
		// The zero limit carries over into the next packet.
		'{ACT_DATA,  8'h3C, 1'b1, 17'h00000, 8'h00, 1'b1, '{8'h3C, 1'b1, 1'b0}},
		// Packet types, known and unknown.
		'{ACT_TYPE,  8'h00, 1'b0, 17'h00000, 8'h02, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_TYPE,  8'hFF, 1'b1, 17'h1FFFF, 8'h04, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_TYPE,  8'h00, 1'b0, 17'h00000, 8'h06, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_TYPE,  8'h00, 1'b0, 17'h00000, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1}},
		'{ACT_TYPE,  8'h00, 1'b0, 17'h00000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
		// Direct limits: most negative and largest positive.
		'{ACT_LIMIT, 8'h00, 1'b0, 17'h10000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_LIMIT, 8'h00, 1'b0, 17'h0FFFF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		// The unused action changes nothing and returns zeros.
		'{ACT_NONE,  8'hFF, 1'b1, 17'h00000, 8'h02, 1'b1, '{8'h00, 1'b0, 1'b0}},
		// A zero limit set mid-packet takes hold at the next word boundary.
		'{ACT_DATA,  8'h55, 1'b0, 17'h00000, 8'h00, 1'b0, '0},
		'{ACT_LIMIT, 8'h00, 1'b0, 17'h00000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ACT_DATA,  8'hAA, 1'b0, 17'h00000, 8'h00, 1'b0, '0},
		'{ACT_DATA,  8'h00, 1'b0, 17'h00000, 8'h00, 1'b0, '0},
		'{ACT_DATA,  8'hFF, 1'b0, 17'h00000, 8'h00, 1'b0, '0},
		'{ACT_DATA,  8'h12, 1'b0, 17'h00000, 8'h00, 1'b1, '{8'h12, 1'b0, 1'b0}},
		'{ACT_DATA,  8'h34, 1'b1, 17'h00000, 8'h00, 1'b1, '{8'h34, 1'b1, 1'b0}},
		'{ACT_LIMIT, 8'h00, 1'b0, 17'h1FFFF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}
	};

	// Block ports.
	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_we        = 1'b0;
	logic               cfg_index     = CFG_KEY;
	logic [BYTE_W-1:0]  cfg_wdata     = '0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [1:0]         action        = ACT_DATA;
	logic [BYTE_W-1:0]  data_byte     = '0;
	logic               end_of_packet = 1'b0;
	logic [LIMIT_W-1:0] limit_value   = '0;
	logic [7:0]         packet_type   = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               out_last;
	logic               type_error;

	// Expectation that travels with a directed row.
	logic        stim_typed = 1'b0;
	cipher_out_t stim_want  = '0;

	// Copy of the block's registers and state.
	logic [BYTE_W-1:0]         key_reg;
	logic                      xor_en_reg;
	logic [STATE_W-1:0]        lcg_value;
	logic [1:0]                byte_pos;
	logic signed [LIMIT_W-1:0] words_left;
	logic                      bypass_rest;

	cipher_out_t awaited_outputs [$];

	int unsigned items_sent      = 0;
	int unsigned ignored_sent    = 0;
	int unsigned results_checked = 0;
	int unsigned error_count     = 0;
	int unsigned bypassed_bytes  = 0;
	int unsigned unknown_types   = 0;
	int unsigned idle_cycles     = 0;
	int unsigned send_idle_pct   = 0;
	int unsigned recv_stall_pct  = 0;
	bit          hold_request    = 1'b0;

	lcg_keystream_xor_cipher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.end_of_packet(end_of_packet),
		.limit_value  (limit_value),
		.packet_type  (packet_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.type_error   (type_error)
	);

	always #2 clk = ~clk;

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS) begin
			$display("%0t ns ERROR: %s", $time, msg);
		end
	endtask

	// Advances the state copy by one item and returns the result it should give.
	function automatic cipher_out_t cipher_predict(input action_t act, input logic [7:0] din,
			input logic eop, input logic [LIMIT_W-1:0] lim, input logic [7:0] ptype);
		cipher_out_t r;
		logic [7:0]  b;
		r = '0;
		case (act)
			ACT_DATA: begin
				b = din;
				if (xor_en_reg && !bypass_rest) begin
					// A word start either advances the generator or hits the limit.
					if (byte_pos == 2'd0) begin
						if (words_left == 0) begin
							bypass_rest = 1'b1;
						end else begin
							lcg_value = lcg_value * LCG_MULT + STATE_W'(key_reg);
							if (words_left > 0) begin
								words_left = words_left - 1;
							end
						end
					end
					if (!bypass_rest) begin
						b = b ^ lcg_value[8*byte_pos +: 8];
					end
				end
				if (bypass_rest) begin
					bypassed_bytes++;
				end
				r.data = b;
				r.last = eop;
				// The byte position and bypass restart with each packet.
				if (eop) begin
					byte_pos    = 2'd0;
					bypass_rest = 1'b0;
				end else begin
					byte_pos = byte_pos + 2'd1;
				end
			end
			ACT_LIMIT: begin
				words_left = lim[LIMIT_W-1] ? LIMIT_UNLIMITED : lim;
			end
			ACT_TYPE: begin
				if (ptype == PTYPE_LONG) begin
					words_left = LIMIT_TYPE_LONG;
				end else if (ptype == PTYPE_SHORT_A || ptype == PTYPE_SHORT_B) begin
					words_left = LIMIT_TYPE_SHORT;
				end else begin
					r.err = 1'b1;
					unknown_types++;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Tracks register writes, predicts each input transfer and checks each output transfer.
	always @(posedge clk) begin
		cipher_out_t got;
		cipher_out_t want;
		if (!arst_n) begin
			key_reg     = '0;
			xor_en_reg  = 1'b1;
			lcg_value   = LCG_START;
			byte_pos    = 2'd0;
			words_left  = LIMIT_UNLIMITED;
			bypass_rest = 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_KEY) begin
					key_reg = cfg_wdata;
				end else begin
					xor_en_reg = cfg_wdata[0];
				end
			end
			// A result can only belong to an item accepted at an earlier edge.
			if (out_valid && out_ready) begin
				got = '{out_byte, out_last, type_error};
				if (awaited_outputs.size() == 0) begin
					report_error($sformatf("result %02h/%0b/%0b with none expected",
						got.data, got.last, got.err));
				end else begin
					want = awaited_outputs.pop_front();
					results_checked++;
					if (got.data !== want.data) begin
						report_error($sformatf("out_byte got %02h expected %02h",
							got.data, want.data));
					end
					if (got.last !== want.last) begin
						report_error($sformatf("out_last got %0b expected %0b",
							got.last, want.last));
					end
					if (got.err !== want.err) begin
						report_error($sformatf("type_error got %0b expected %0b",
							got.err, want.err));
					end
				end
			end
			if (in_valid && in_ready) begin
				want = cipher_predict(action_t'(action), data_byte, end_of_packet,
					limit_value, packet_type);
				if (stim_typed) begin
					want = stim_want;
				end
				awaited_outputs.push_back(want);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off on request so that the block backs up.
	always begin
		@(posedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run after too many cycles with no transfer at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer", idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offers one item after a random gap and holds it until the transfer.
	task automatic send_item(input action_t act, input logic [7:0] din, input logic eop,
			input logic [LIMIT_W-1:0] lim, input logic [7:0] ptype,
			input logic typed, input cipher_out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		data_byte     <= din;
		end_of_packet <= eop;
		limit_value   <= lim;
		packet_type   <= ptype;
		stim_typed    <= typed;
		stim_want     <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (act == ACT_NONE) begin
			ignored_sent++;
		end
	endtask

	// Limit action: mostly small limits so that they run out, sometimes any value.
	task automatic send_random_limit();
		logic [LIMIT_W-1:0] lim;
		lim = ($urandom_range(3) == 0) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(0, 6));
		send_item(ACT_LIMIT, 8'($urandom), 1'($urandom), lim, 8'($urandom), 1'b0, '0);
	endtask

	// Type action: mostly known types, sometimes any value.
	task automatic send_random_type();
		logic [7:0] ptype;
		case ($urandom_range(3))
			0: ptype = PTYPE_LONG;
			1: ptype = PTYPE_SHORT_A;
			2: ptype = PTYPE_SHORT_B;
			default: ptype = 8'($urandom);
		endcase
		send_item(ACT_TYPE, 8'($urandom), 1'($urandom), LIMIT_W'($urandom), ptype, 1'b0, '0);
	endtask

	// A packet of random bytes, often preceded by a limit, with some noise inside it.
	task automatic send_random_packet();
		int unsigned len;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			send_random_limit();
		end else if (pick < 45) begin
			send_random_type();
		end
		len = $urandom_range(1, 20);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(99) < 5) begin
				case ($urandom_range(2))
					0: send_random_limit();
					1: send_random_type();
					default: send_item(ACT_NONE, 8'($urandom), 1'($urandom),
						LIMIT_W'($urandom), 8'($urandom), 1'b0, '0);
				endcase
			end
			send_item(ACT_DATA, 8'($urandom), 1'(k == len - 1), LIMIT_W'($urandom),
				8'($urandom), 1'b0, '0);
		end
	endtask

	// Drops valid, waits for every awaited result, then lets the pipeline go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (results_checked != items_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges.
	task automatic write_config(input logic [7:0] key, input logic enable);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_index <= CFG_XOR_EN;
		cfg_wdata <= {7'd0, enable};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Main sequence: reset, directed table, then random phases with different settings.
	initial begin
		int unsigned phase_start;
		logic [7:0]  key;
		logic        enable;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_config(8'h00, 1'b1);
		for (int unsigned i = 0; i < NUM_ROWS; i++) begin
			send_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].eop,
				directed_rows[i].limit, directed_rows[i].ptype, directed_rows[i].typed,
				directed_rows[i].want);
		end
		settle();

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			// Key extremes, the cipher off once, and each idling pattern.
			case (p)
				0: begin key = 8'hFF;        enable = 1'b1; send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin key = 8'h00;        enable = 1'b1; send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin key = 8'($urandom); enable = 1'b0; send_idle_pct = 0;  recv_stall_pct = 85; end
				3: begin key = 8'h80;        enable = 1'b1; send_idle_pct = 10; recv_stall_pct = 10; end
				default: begin
					key = 8'($urandom); enable = 1'b1; send_idle_pct = 0; recv_stall_pct = 0;
				end
			endcase
			write_config(key, enable);
			if (p == 0 || p == 3) begin
				hold_request = 1'b1;
			end
			phase_start = items_sent - ignored_sent;
			while (items_sent - ignored_sent - phase_start < PHASE_ITEMS) begin
				send_random_packet();
			end
			settle();
		end

		@(negedge clk);
		if (awaited_outputs.size() != 0) begin
			report_error($sformatf("%0d results never arrived", awaited_outputs.size()));
		end
		$display("Run covered %0d items and %0d checked results over %0d register settings.",
			items_sent, results_checked, NUM_PHASES + 1);
		$display("Word limit bypassed %0d bytes; %0d unknown packet types were flagged.",
			bypassed_bytes, unknown_types);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
